/* src/pcsg_pkg.sv */
// Shared types and constants for the palette color shift and gamma unit.
// No dependencies; every other file of the block refers to it by scoped names.
package pcsg_pkg;

   localparam int SHIFT_SLOTS_DEF = 4;
   localparam int TABLE_ENTRIES   = 256;
   localparam int TBL_AW          = $clog2(TABLE_ENTRIES);
   localparam int CHAN_W          = 8;
   localparam int COUNT_W         = 3;
   localparam int CSR_AW          = 5;
   localparam int CSR_DW          = 32;
   localparam int REG_IDX_W       = 3;
   localparam int NUM_SHIFT_REGS  = 4;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_XFORM = 1'b1;

   localparam logic [REG_IDX_W-1:0] REG_SHIFT_COUNT = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SHIFT_ZERO  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SHIFT_ONE   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SHIFT_TWO   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SHIFT_THREE = 3'd4;

   typedef struct packed {
      logic              func;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [TBL_AW-1:0] table_index;
      logic [CHAN_W-1:0] table_value;
   } item_type;

   // packing of one shift register: percent, then target red, green, blue
   typedef struct packed {
      logic [CHAN_W-1:0] percent;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } shift_type;

endpackage

/* src/pcsg_chan_if.sv */
// Valid/ready channel interfaces for the request and response sides.
// Depends on pcsg_pkg for field widths.
interface pcsg_req_if;
   logic                            valid;
   logic                            ready;
   logic                            func;
   logic [pcsg_pkg::CHAN_W-1:0]     red_in;
   logic [pcsg_pkg::CHAN_W-1:0]     green_in;
   logic [pcsg_pkg::CHAN_W-1:0]     blue_in;
   logic [pcsg_pkg::TBL_AW-1:0]     table_index;
   logic [pcsg_pkg::CHAN_W-1:0]     table_value;

   modport source (output valid, func, red_in, green_in, blue_in, table_index, table_value,
                   input ready);
   modport sink   (input valid, func, red_in, green_in, blue_in, table_index, table_value,
                   output ready);
endinterface

interface pcsg_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pcsg_pkg::CHAN_W-1:0] red_out;
   logic [pcsg_pkg::CHAN_W-1:0] green_out;
   logic [pcsg_pkg::CHAN_W-1:0] blue_out;

   modport source (output valid, red_out, green_out, blue_out, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

/* src/pcsg_shift_cell.sv */
// One cell of the shift chain: applies one color shift to a transaction when active and holds it.
// Depends on pcsg_pkg.
module pcsg_shift_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                active,
   input  pcsg_pkg::shift_type shift,
   input  logic                in_valid,
   output logic                in_ready,
   input  pcsg_pkg::item_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output pcsg_pkg::item_type  out_data
);

   // c + floor(pct * (d - c) / 256); upper bits of the product give the floor
   function automatic logic [pcsg_pkg::CHAN_W-1:0] blend_chan(
      input logic [pcsg_pkg::CHAN_W-1:0] c,
      input logic [pcsg_pkg::CHAN_W-1:0] d,
      input logic [pcsg_pkg::CHAN_W-1:0] pct);
      logic signed [pcsg_pkg::CHAN_W:0]     diff;
      logic signed [2*pcsg_pkg::CHAN_W+1:0] prod;
      logic signed [pcsg_pkg::CHAN_W+1:0]   step_v;
      logic signed [pcsg_pkg::CHAN_W+1:0]   sum;
      diff   = $signed({1'b0, d}) - $signed({1'b0, c});
      prod   = $signed({1'b0, pct}) * diff;
      step_v = prod[2*pcsg_pkg::CHAN_W+1:pcsg_pkg::CHAN_W];
      sum    = $signed({2'b00, c}) + step_v;
      return sum[pcsg_pkg::CHAN_W-1:0];
   endfunction

   logic               valid_ff;
   pcsg_pkg::item_type data_ff;
   pcsg_pkg::item_type data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      data_in = in_data;
      if (active) begin
         data_in.red   = blend_chan(in_data.red,   shift.red,   shift.percent);
         data_in.green = blend_chan(in_data.green, shift.green, shift.percent);
         data_in.blue  = blend_chan(in_data.blue,  shift.blue,  shift.percent);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   // a stalled cell keeps its transaction
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable(data_ff))
      else $error("shift cell lost or changed a stalled transaction");

   // an inactive cell passes colors unchanged
   a_bypass: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready && !active |=> data_ff == $past(in_data))
      else $error("inactive shift cell altered a transaction");

endmodule

/* src/pcsg_gamma_lut.sv */
// Gamma lookup stage: three table copies (one per channel), valid bits for the
// identity reset, and the output register. Depends on pcsg_pkg.
module pcsg_gamma_lut (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  pcsg_pkg::item_type          in_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [pcsg_pkg::CHAN_W-1:0] out_red,
   output logic [pcsg_pkg::CHAN_W-1:0] out_green,
   output logic [pcsg_pkg::CHAN_W-1:0] out_blue
);

   localparam int LANES = 3;

   logic                              out_valid_ff;
   logic [pcsg_pkg::TABLE_ENTRIES-1:0] loaded_ff;
   logic                              take;
   logic                              take_load;
   logic                              take_xform;
   logic [pcsg_pkg::TBL_AW-1:0]       rd_addr [LANES];
   logic [pcsg_pkg::TBL_AW-1:0]       addr_ff [LANES];
   logic [pcsg_pkg::CHAN_W-1:0]       rd_ff   [LANES];
   logic [LANES-1:0]                  hit_ff;
   logic [pcsg_pkg::CHAN_W-1:0]       lane_out [LANES];

   assign in_ready   = !out_valid_ff || out_ready;
   assign take       = in_valid && in_ready;
   assign take_load  = take && (in_data.func == pcsg_pkg::FUNC_LOAD);
   assign take_xform = take && (in_data.func == pcsg_pkg::FUNC_XFORM);

   assign rd_addr[0] = in_data.red[pcsg_pkg::TBL_AW-1:0];
   assign rd_addr[1] = in_data.green[pcsg_pkg::TBL_AW-1:0];
   assign rd_addr[2] = in_data.blue[pcsg_pkg::TBL_AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (in_ready) begin
         out_valid_ff <= in_valid && (in_data.func == pcsg_pkg::FUNC_XFORM);
      end
   end

   // entries never loaded read as identity
   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
      end else if (take_load) begin
         loaded_ff[in_data.table_index] <= 1'b1;
      end
   end

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      logic [pcsg_pkg::CHAN_W-1:0] mem [pcsg_pkg::TABLE_ENTRIES];

      always_ff @(posedge clock) begin
         if (take_load) begin
            mem[in_data.table_index] <= in_data.table_value;
         end
      end

      always_ff @(posedge clock) begin
         if (take_xform) begin
            rd_ff[k]   <= mem[rd_addr[k]];
            hit_ff[k]  <= loaded_ff[rd_addr[k]];
            addr_ff[k] <= rd_addr[k];
         end
      end

      assign lane_out[k] = hit_ff[k] ? rd_ff[k] : pcsg_pkg::CHAN_W'(addr_ff[k]);
   end

   assign out_valid = out_valid_ff;
   assign out_red   = lane_out[0];
   assign out_green = lane_out[1];
   assign out_blue  = lane_out[2];

   // a table load never produces a response
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      take_load |=> !out_valid_ff)
      else $error("table load produced a response");

   a_load_marks: assert property (@(posedge clock) disable iff (reset)
      take_load |=> loaded_ff[$past(in_data.table_index)])
      else $error("table load did not mark its entry");

endmodule

/* src/palette_color_shift_gamma_unit.sv */
// Top level of the palette color shift and gamma unit: CSR block, shift-cell chain
// and gamma lookup stage. Depends on pcsg_pkg, pcsg_chan_if, pcsg_shift_cell, pcsg_gamma_lut.
//
// Usage:
//  req_ch carries one transaction per accepted valid/ready handshake. func = 1 sends
//  a color (red_in, green_in, blue_in) through the active color shifts and the gamma
//  table and yields one response on rsp_ch; func = 0 writes table_value into gamma
//  entry table_index and yields no response. Transactions stay in order, so a load
//  affects every color that follows it.
//  The CSR port holds shift_count and up to four shift words (percent, target RGB).
//  Write them only while no transaction is in flight.
//  A color passes through one register per shift cell in the chain and then the
//  registered table read before rsp_ch.valid. Throughput is one transaction per cycle
//  while rsp_ch.ready is high; each cell holds one transaction and passes it on.
//  When rsp_ch.ready is low the result stays in the output register and the chain
//  keeps filling until every cell holds a transaction, then req_ch.ready falls.
//  Reset clears the CSR registers, empties the chain and returns the gamma table to
//  identity at once (per-entry valid bits); no clearing pass is needed.
module palette_color_shift_gamma_unit #(
   parameter int SHIFT_SLOTS = pcsg_pkg::SHIFT_SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   pcsg_req_if.sink                      req_ch,
   pcsg_rsp_if.source                    rsp_ch,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [pcsg_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [pcsg_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [pcsg_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);

   // wide enough for any slot number and any raw count value
   localparam int SLOT_W = pcsg_pkg::COUNT_W + 1;

   logic [pcsg_pkg::REG_IDX_W-1:0] reg_idx;
   logic [1:0]                     rel_idx;
   logic                           csr_wr;
   logic [pcsg_pkg::COUNT_W-1:0]   shift_count_ff;
   logic [pcsg_pkg::CSR_DW-1:0]    slot_word [SHIFT_SLOTS];
   logic [pcsg_pkg::CSR_DW-1:0]    reg_view  [pcsg_pkg::NUM_SHIFT_REGS];

   pcsg_pkg::item_type chain_data [SHIFT_SLOTS+1];
   logic [SHIFT_SLOTS:0] chain_valid;
   logic [SHIFT_SLOTS:0] chain_ready;

   assign reg_idx    = csr_paddr[pcsg_pkg::CSR_AW-1:2];
   assign rel_idx    = 2'(reg_idx - pcsg_pkg::REG_SHIFT_ZERO);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_count_ff <= '0;
      end else if (csr_wr && reg_idx == pcsg_pkg::REG_SHIFT_COUNT) begin
         shift_count_ff <= csr_pwdata[pcsg_pkg::COUNT_W-1:0];
      end
   end

   // slots past the register set stay at zero percent
   for (genvar j = 0; j < SHIFT_SLOTS; j++) begin : g_slot
      if (j < pcsg_pkg::NUM_SHIFT_REGS) begin : g_reg
         logic [pcsg_pkg::CSR_DW-1:0] word_ff;
         always_ff @(posedge clock) begin
            if (reset) begin
               word_ff <= '0;
            end else if (csr_wr &&
                         reg_idx == pcsg_pkg::REG_SHIFT_ZERO + pcsg_pkg::REG_IDX_W'(j)) begin
               word_ff <= csr_pwdata;
            end
         end
         assign slot_word[j] = word_ff;
      end else begin : g_none
         assign slot_word[j] = '0;
      end
   end

   for (genvar r = 0; r < pcsg_pkg::NUM_SHIFT_REGS; r++) begin : g_view
      if (r < SHIFT_SLOTS) begin : g_on
         assign reg_view[r] = slot_word[r];
      end else begin : g_off
         assign reg_view[r] = '0;
      end
   end

   always_comb begin
      unique case (reg_idx) inside
         pcsg_pkg::REG_SHIFT_COUNT:
            csr_prdata = pcsg_pkg::CSR_DW'(shift_count_ff);
         pcsg_pkg::REG_SHIFT_ZERO, pcsg_pkg::REG_SHIFT_ONE,
         pcsg_pkg::REG_SHIFT_TWO, pcsg_pkg::REG_SHIFT_THREE:
            csr_prdata = reg_view[rel_idx];
         default:
            csr_prdata = '0;
      endcase
   end

   assign chain_valid[0]             = req_ch.valid;
   assign req_ch.ready               = chain_ready[0];
   assign chain_data[0].func         = req_ch.func;
   assign chain_data[0].red          = req_ch.red_in;
   assign chain_data[0].green        = req_ch.green_in;
   assign chain_data[0].blue         = req_ch.blue_in;
   assign chain_data[0].table_index  = req_ch.table_index;
   assign chain_data[0].table_value  = req_ch.table_value;

   for (genvar j = 0; j < SHIFT_SLOTS; j++) begin : g_cell
      logic active;
      // a count above the slot total simply enables every cell
      assign active = SLOT_W'(j) < SLOT_W'(shift_count_ff);

      pcsg_shift_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .active    (active),
         .shift     (pcsg_pkg::shift_type'(slot_word[j])),
         .in_valid  (chain_valid[j]),
         .in_ready  (chain_ready[j]),
         .in_data   (chain_data[j]),
         .out_valid (chain_valid[j+1]),
         .out_ready (chain_ready[j+1]),
         .out_data  (chain_data[j+1])
      );
   end

   pcsg_gamma_lut u_lut (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[SHIFT_SLOTS]),
      .in_ready  (chain_ready[SHIFT_SLOTS]),
      .in_data   (chain_data[SHIFT_SLOTS]),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_red   (rsp_ch.red_out),
      .out_green (rsp_ch.green_out),
      .out_blue  (rsp_ch.blue_out)
   );

   a_count_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr && reg_idx == pcsg_pkg::REG_SHIFT_COUNT
      |=> shift_count_ff == $past(csr_pwdata[pcsg_pkg::COUNT_W-1:0]))
      else $error("shift_count write not taken");

   a_slot0_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr && reg_idx == pcsg_pkg::REG_SHIFT_ZERO |=> slot_word[0] == $past(csr_pwdata))
      else $error("first shift word write not taken");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for palette_color_shift_gamma_unit: directed and random
// color and gamma-load transactions checked against an in-bench color predictor.
// Depends on pcsg_pkg, pcsg_chan_if and the unit's RTL.
module testbench;

   localparam int SHIFT_SLOTS      = pcsg_pkg::SHIFT_SLOTS_DEF;
   localparam int PIPE_LATENCY     = SHIFT_SLOTS + 1;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int HOLD_CYCLES      = 300;
   localparam int RANDOM_PER_PHASE = 188;
   localparam int MAX_REPORTS      = 10;

   // register indexes that map to no register
   localparam logic [pcsg_pkg::REG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
   localparam logic [pcsg_pkg::REG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [pcsg_pkg::CHAN_W-1:0] red;
      logic [pcsg_pkg::CHAN_W-1:0] green;
      logic [pcsg_pkg::CHAN_W-1:0] blue;
   } rgb_type;

   logic                          clock;
   logic                          reset;
   logic                          csr_psel;
   logic                          csr_penable;
   logic                          csr_pwrite;
   logic [pcsg_pkg::CSR_AW-1:0]   csr_paddr;
   logic [pcsg_pkg::CSR_DW-1:0]   csr_pwdata;
   logic [pcsg_pkg::CSR_DW-1:0]   csr_prdata;
   logic                          csr_pready;

   pcsg_req_if req_ch ();
   pcsg_rsp_if rsp_ch ();

   palette_color_shift_gamma_unit #(
      .SHIFT_SLOTS (SHIFT_SLOTS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow of the unit's programmable state
   logic [pcsg_pkg::COUNT_W-1:0]  shift_count_shadow;
   logic [pcsg_pkg::CSR_DW-1:0]   shift_word_shadow [pcsg_pkg::NUM_SHIFT_REGS];
   logic [pcsg_pkg::CHAN_W-1:0]   gamma_shadow [pcsg_pkg::TABLE_ENTRIES];

   rgb_type pending_colors [$];
   int      mismatch_count = 0;
   int      cycle_count = 0;
   int      send_idle_pct;
   int      recv_idle_pct;
   int      hold_requests;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor
   function automatic rgb_type shade_color(input logic [pcsg_pkg::CHAN_W-1:0] r, g, b);
      int                  chan [3];
      int                  active;
      int                  pct;
      pcsg_pkg::shift_type sw;
      rgb_type             res;
      chan[0] = int'(r);
      chan[1] = int'(g);
      chan[2] = int'(b);
      active  = (int'(shift_count_shadow) > SHIFT_SLOTS) ? SHIFT_SLOTS
                                                         : int'(shift_count_shadow);
      for (int j = 0; j < active; j++) begin
         sw  = pcsg_pkg::shift_type'(shift_word_shadow[j]);
         pct = int'(sw.percent);
         // >>> floors toward minus infinity, as the blend requires
         chan[0] = chan[0] + ((pct * (int'(sw.red)   - chan[0])) >>> 8);
         chan[1] = chan[1] + ((pct * (int'(sw.green) - chan[1])) >>> 8);
         chan[2] = chan[2] + ((pct * (int'(sw.blue)  - chan[2])) >>> 8);
      end
      res.red   = gamma_shadow[8'(chan[0])];
      res.green = gamma_shadow[8'(chan[1])];
      res.blue  = gamma_shadow[8'(chan[2])];
      return res;
   endfunction

   // apply an accepted transaction to the shadow state
   task automatic absorb_item(input pcsg_pkg::item_type it);
      if (it.func == pcsg_pkg::FUNC_LOAD) begin
         gamma_shadow[it.table_index] = it.table_value;
      end else begin
         pending_colors.push_back(shade_color(it.red, it.green, it.blue));
      end
   endtask

   // ---------------------------------------------------------------- stimulus
   function automatic logic [pcsg_pkg::CHAN_W-1:0] rand_chan();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return pcsg_pkg::CHAN_W'($urandom);
   endfunction

   function automatic pcsg_pkg::item_type make_color(input logic [pcsg_pkg::CHAN_W-1:0] r, g, b);
      pcsg_pkg::item_type it;
      it.func        = pcsg_pkg::FUNC_XFORM;
      it.red         = r;
      it.green       = g;
      it.blue        = b;
      it.table_index = pcsg_pkg::TBL_AW'($urandom);
      it.table_value = pcsg_pkg::CHAN_W'($urandom);
      return it;
   endfunction

   function automatic pcsg_pkg::item_type make_load(input logic [pcsg_pkg::TBL_AW-1:0] idx,
                                                    input logic [pcsg_pkg::CHAN_W-1:0] val);
      pcsg_pkg::item_type it;
      it.func        = pcsg_pkg::FUNC_LOAD;
      it.red         = pcsg_pkg::CHAN_W'($urandom);
      it.green       = pcsg_pkg::CHAN_W'($urandom);
      it.blue        = pcsg_pkg::CHAN_W'($urandom);
      it.table_index = idx;
      it.table_value = val;
      return it;
   endfunction

   function automatic pcsg_pkg::item_type random_item();
      if ($urandom_range(0, 99) < 20)
         return make_load(rand_chan(), rand_chan());
      return make_color(rand_chan(), rand_chan(), rand_chan());
   endfunction

   task automatic send_item(input pcsg_pkg::item_type it);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.func        <= it.func;
      req_ch.red_in      <= it.red;
      req_ch.green_in    <= it.green;
      req_ch.blue_in     <= it.blue;
      req_ch.table_index <= it.table_index;
      req_ch.table_value <= it.table_value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      absorb_item(it);
   endtask

   // stop sending, let all results drain, then cover loads still in the chain
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_colors.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 3) @(posedge clock);
   endtask

   task automatic csr_write(input logic [pcsg_pkg::REG_IDX_W-1:0] idx,
                            input logic [pcsg_pkg::CSR_DW-1:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      case (idx)
         pcsg_pkg::REG_SHIFT_COUNT: shift_count_shadow = val[pcsg_pkg::COUNT_W-1:0];
         pcsg_pkg::REG_SHIFT_ZERO, pcsg_pkg::REG_SHIFT_ONE,
         pcsg_pkg::REG_SHIFT_TWO, pcsg_pkg::REG_SHIFT_THREE:
            shift_word_shadow[2'(idx - pcsg_pkg::REG_SHIFT_ZERO)] = val;
         default: ;
      endcase
   endtask

   task automatic set_shifts(input logic [pcsg_pkg::COUNT_W-1:0] count,
                             input logic [pcsg_pkg::CSR_DW-1:0] w0, w1, w2, w3);
      wait_idle();
      // upper bits of the count word carry junk; only the low bits matter
      csr_write(pcsg_pkg::REG_SHIFT_COUNT,
                {$urandom} & ~pcsg_pkg::CSR_DW'(7) | pcsg_pkg::CSR_DW'(count));
      csr_write(pcsg_pkg::REG_SHIFT_ZERO,  w0);
      csr_write(pcsg_pkg::REG_SHIFT_ONE,   w1);
      csr_write(pcsg_pkg::REG_SHIFT_TWO,   w2);
      csr_write(pcsg_pkg::REG_SHIFT_THREE, w3);
   endtask

   function automatic logic [pcsg_pkg::CSR_DW-1:0] random_word(input bit extreme);
      pcsg_pkg::shift_type sw;
      sw = pcsg_pkg::shift_type'($urandom);
      if (extreme) begin
         sw.percent = $urandom_range(0, 1) ? '1 : '0;
         sw.red     = $urandom_range(0, 1) ? '1 : '0;
         sw.green   = $urandom_range(0, 1) ? '1 : '0;
         sw.blue    = $urandom_range(0, 1) ? '1 : '0;
      end else if ($urandom_range(0, 3) == 0) begin
         sw.percent = $urandom_range(0, 1) ? '1 : '0;
      end
      return pcsg_pkg::CSR_DW'(sw);
   endfunction

   task automatic program_random_shifts(input bit extreme);
      logic [pcsg_pkg::COUNT_W-1:0] count;
      int                           pick;
      pick = $urandom_range(0, 2);
      if (extreme)
         count = (pick == 0) ? 3'd0 : (pick == 1) ? pcsg_pkg::COUNT_W'(SHIFT_SLOTS) : 3'd7;
      else
         count = pcsg_pkg::COUNT_W'($urandom_range(0, 7));
      set_shifts(count, random_word(extreme), random_word(extreme),
                 random_word(extreme), random_word(extreme));
   endtask

   // ---------------------------------------------------------------- receiver
   initial begin
      int hold_left;
      int holds_seen;
      hold_left  = 0;
      holds_seen = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_seen) begin
            holds_seen = hold_requests;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   task automatic report_color_error(input bit had_expect, input rgb_type want,
                                     input rgb_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         if (had_expect)
            $display("%0t: color mismatch, expected r=%02h g=%02h b=%02h, got r=%02h g=%02h b=%02h",
                     $realtime, want.red, want.green, want.blue, got.red, got.green, got.blue);
         else
            $display("%0t: unexpected transaction, got r=%02h g=%02h b=%02h",
                     $realtime, got.red, got.green, got.blue);
      end
   endtask

   always @(posedge clock) begin
      rgb_type want;
      rgb_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.red   = rsp_ch.red_out;
         got.green = rsp_ch.green_out;
         got.blue  = rsp_ch.blue_out;
         if (pending_colors.size() == 0) begin
            report_color_error(1'b0, got, got);
         end else begin
            want = pending_colors.pop_front();
            if (want.red !== got.red || want.green !== got.green || want.blue !== got.blue)
               report_color_error(1'b1, want, got);
         end
      end
   end

   // ---------------------------------------------------------------- tests
   task automatic test_identity_after_reset();
      send_item(make_color(8'h00, 8'h00, 8'h00));
      send_item(make_color(8'hFF, 8'hFF, 8'hFF));
      send_item(make_color(8'h55, 8'hAA, 8'h0F));
      send_item(make_color(8'hAA, 8'h55, 8'hF0));
   endtask

   task automatic test_gamma_loads();
      send_item(make_load(8'h00, 8'hFF));
      send_item(make_load(8'hFF, 8'h00));
      send_item(make_load(8'h5A, 8'hA5));
      send_item(make_color(8'h00, 8'hFF, 8'h5A));
      // rewrite an entry and use it straight away
      send_item(make_load(8'h00, 8'h12));
      send_item(make_color(8'h00, 8'h00, 8'h00));
   endtask

   task automatic test_shift_extremes();
      set_shifts(3'd1, pcsg_pkg::CSR_DW'(pcsg_pkg::shift_type'{8'hFF, 8'h00, 8'h00, 8'h00}),
                 '0, '0, '0);
      send_item(make_color(8'hFF, 8'hFF, 8'hFF));
      send_item(make_color(8'h80, 8'h01, 8'hFE));
      set_shifts(3'd1, pcsg_pkg::CSR_DW'(pcsg_pkg::shift_type'{8'hFF, 8'hFF, 8'hFF, 8'hFF}),
                 '0, '0, '0);
      send_item(make_color(8'h00, 8'h00, 8'h00));
      send_item(make_color(8'h7F, 8'hFF, 8'h00));
      set_shifts(pcsg_pkg::COUNT_W'(SHIFT_SLOTS),
                 pcsg_pkg::CSR_DW'(pcsg_pkg::shift_type'{8'h00, 8'hFF, 8'h00, 8'hFF}),
                 $urandom, $urandom, $urandom);
      send_item(make_color(rand_chan(), rand_chan(), rand_chan()));
      send_item(make_color(rand_chan(), rand_chan(), rand_chan()));
      // count above the slot total saturates
      set_shifts(3'd7, $urandom, $urandom, $urandom, $urandom);
      send_item(make_color(rand_chan(), rand_chan(), rand_chan()));
      // writes past the last register change nothing
      wait_idle();
      for (int idx = REG_UNUSED_LO; idx <= REG_UNUSED_HI; idx++)
         csr_write(pcsg_pkg::REG_IDX_W'(idx), $urandom);
      send_item(make_color(rand_chan(), rand_chan(), rand_chan()));
      set_shifts(3'd0, $urandom, $urandom, $urandom, $urandom);
      send_item(make_color(rand_chan(), rand_chan(), rand_chan()));
   endtask

   task automatic test_random_traffic();
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0:       begin send_idle_pct = 14; recv_idle_pct = 57; end
            1:       begin send_idle_pct = 57; recv_idle_pct = 14; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase
         for (int phase = 0; phase < 3; phase++) begin
            program_random_shifts(phase == 0);
            repeat (RANDOM_PER_PHASE) send_item(random_item());
         end
      end
   endtask

   task automatic test_output_backpressure();
      program_random_shifts(1'b0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // long receiver hold-off while colors keep coming; the chain fills and stalls
      hold_requests <= hold_requests + 1;
      repeat (40) send_item(make_color(rand_chan(), rand_chan(), rand_chan()));
      wait_idle();
      send_idle_pct = 14;
      recv_idle_pct = 57;
      repeat (20) send_item(random_item());
   endtask

   initial begin
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.func        <= pcsg_pkg::FUNC_XFORM;
      req_ch.red_in      <= '0;
      req_ch.green_in    <= '0;
      req_ch.blue_in     <= '0;
      req_ch.table_index <= '0;
      req_ch.table_value <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      hold_requests      = 0;
      send_idle_pct      = 14;
      recv_idle_pct      = 57;
      shift_count_shadow = '0;
      for (int i = 0; i < pcsg_pkg::NUM_SHIFT_REGS; i++) shift_word_shadow[i] = '0;
      for (int i = 0; i < pcsg_pkg::TABLE_ENTRIES; i++)
         gamma_shadow[i] = pcsg_pkg::CHAN_W'(i);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_identity_after_reset();
      test_gamma_loads();
      test_shift_extremes();
      test_random_traffic();
      test_output_backpressure();

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_colors.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 5) @(posedge clock);
      if (mismatch_count == 0 && pending_colors.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
